[hdl/cbe_pkg.sv]
`timescale 1ns / 1ps

package cbe_pkg;

   localparam int FRAC_BITS = 16;
   localparam int T_W       = FRAC_BITS + 1;
   localparam int P_W       = 32;
   localparam int V_W       = 40;
   localparam int SEL_W     = 2;
   localparam int STEPS     = 3;
   localparam int PROD_W    = V_W + T_W + 1;
   localparam int REQ_W     = ((T_W + 4 * P_W + 7) / 8) * 8;
   localparam int RSP_W     = ((V_W + 7) / 8) * 8;

   localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

   localparam logic [SEL_W-1:0] SEL_POS = 2'd0;
   localparam logic [SEL_W-1:0] SEL_D1  = 2'd1;
   localparam logic [SEL_W-1:0] SEL_D2  = 2'd2;

   // One item on its way through the Horner steps. Lane 0 of addend and
   // mul_en belongs to the next step; each step shifts both down by one lane.
   typedef struct packed {
      logic signed [V_W-1:0]       acc;
      logic [T_W-1:0]              t;
      logic [STEPS-1:0][V_W-1:0]   addend;
      logic [STEPS-1:0]            mul_en;
   } beat_type;

endpackage

[hdl/cbe_coef.sv]
`timescale 1ns / 1ps

module cbe_coef (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [cbe_pkg::SEL_W-1:0]   sel,
   input  logic [cbe_pkg::T_W-1:0]     param_t,
   input  logic [cbe_pkg::P_W-1:0]     p0,
   input  logic [cbe_pkg::P_W-1:0]     p1,
   input  logic [cbe_pkg::P_W-1:0]     p2,
   input  logic [cbe_pkg::P_W-1:0]     p3,
   output logic                        out_valid,
   input  logic                        out_ready,
   output cbe_pkg::beat_type           out_beat
);
   import cbe_pkg::*;

   logic signed [V_W-1:0] p0_x, p1_x, p2_x, p3_x;
   logic signed [V_W-1:0] coef_a, coef_b, coef_c, sum_b, diff_c;
   logic signed [V_W-1:0] coef_a3, coef_a6, coef_b2;
   logic [T_W-1:0]        t_sat;
   beat_type              beat_in;
   beat_type              beat_ff;
   logic                  valid_ff;

   assign p0_x = {{(V_W-P_W){p0[P_W-1]}}, p0};
   assign p1_x = {{(V_W-P_W){p1[P_W-1]}}, p1};
   assign p2_x = {{(V_W-P_W){p2[P_W-1]}}, p2};
   assign p3_x = {{(V_W-P_W){p3[P_W-1]}}, p3};

   assign coef_a  = p3_x - (p2_x <<< 1) - p2_x + (p1_x <<< 1) + p1_x - p0_x;
   assign sum_b   = p0_x - (p1_x <<< 1) + p2_x;
   assign coef_b  = (sum_b <<< 1) + sum_b;
   assign diff_c  = p1_x - p0_x;
   assign coef_c  = (diff_c <<< 1) + diff_c;
   assign coef_a3 = (coef_a <<< 1) + coef_a;
   assign coef_a6 = coef_a3 <<< 1;
   assign coef_b2 = coef_b <<< 1;

   // A parameter beyond one is held at one.
   assign t_sat = (param_t > T_ONE) ? T_ONE : param_t;

   // The derivatives use fewer Horner steps; their leading steps pass through.
   always_comb begin
      beat_in.t      = t_sat;
      beat_in.acc    = '0;
      beat_in.addend = '0;
      beat_in.mul_en = '0;
      unique case (sel)
         SEL_POS: begin
            beat_in.acc       = coef_a;
            beat_in.addend[0] = coef_b;
            beat_in.addend[1] = coef_c;
            beat_in.addend[2] = p0_x;
            beat_in.mul_en    = 3'b111;
         end
         SEL_D1: begin
            beat_in.acc       = coef_a3;
            beat_in.addend[1] = coef_b2;
            beat_in.addend[2] = coef_c;
            beat_in.mul_en    = 3'b110;
         end
         SEL_D2: begin
            beat_in.acc       = coef_a6;
            beat_in.addend[2] = coef_b2;
            beat_in.mul_en    = 3'b100;
         end
         default: begin
            beat_in.acc = '0;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

[hdl/cbe_step.sv]
`timescale 1ns / 1ps

module cbe_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cbe_pkg::beat_type   in_beat,
   output logic                out_valid,
   input  logic                out_ready,
   output cbe_pkg::beat_type   out_beat
);
   import cbe_pkg::*;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

   logic                     mul_valid_ff;
   beat_type                 mul_beat_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic                     mul_ready;
   logic                     add_valid_ff;
   beat_type                 add_beat_in, add_beat_ff;
   logic                     add_ready;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [V_W-1:0]    acc_sum;

   assign add_ready = !add_valid_ff || out_ready;
   assign mul_ready = !mul_valid_ff || add_ready;
   assign in_ready  = mul_ready;

   assign prod_in = $signed(in_beat.acc) * $signed({1'b0, in_beat.t});

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && in_valid) begin
         mul_beat_ff <= in_beat;
         prod_ff     <= prod_in;
      end
   end

   // Round half up, then drop the fraction bits of t.
   assign prod_rnd = (prod_ff + ROUND_HALF) >>> FRAC_BITS;
   assign acc_sum  = prod_rnd[V_W-1:0] + $signed(mul_beat_ff.addend[0]);

   always_comb begin
      add_beat_in        = mul_beat_ff;
      add_beat_in.acc    = mul_beat_ff.mul_en[0] ? acc_sum : mul_beat_ff.acc;
      add_beat_in.addend = {V_W'(0), mul_beat_ff.addend[STEPS-1:1]};
      add_beat_in.mul_en = {1'b0, mul_beat_ff.mul_en[STEPS-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         add_valid_ff <= 1'b0;
      end else if (add_ready) begin
         add_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (add_ready && mul_valid_ff) begin
         add_beat_ff <= add_beat_in;
      end
   end

   assign out_valid = add_valid_ff;
   assign out_beat  = add_beat_ff;

`ifndef SYNTHESIS
   a_mul_hold: assert property (@(posedge clock) disable iff (reset)
      mul_valid_ff && !add_ready |=> mul_valid_ff && $stable(prod_ff))
      else $error("product stage lost or changed a stalled beat");
`endif

endmodule

[hdl/cubic_bezier_eval.sv]
`timescale 1ns / 1ps

// Cubic Bezier evaluator for one coordinate per beat.
// Input beat (req_): four control-point values in signed Q16.16, the curve
// parameter t in unsigned Q1.16 (values above 1.0 are held at 1.0) and a
// selector in req_tuser: 0 position, 1 first derivative, 2 second
// derivative, 3 returns zero. Every input beat yields exactly one result
// beat (rsp_) holding a 40-bit signed Q24.16 value, in input order.
// The curve is evaluated by Horner's rule: one coefficient stage, then
// three multiply-round-add steps of two register stages each. An accepted
// beat passes the coefficient register, then the product and sum registers
// of each step in turn; unless the pipeline is full, one beat is taken every
// cycle, set by the fully pipelined 40 x 18 bit multiplier in each step.
// Each stage has its own valid bit and a ready that looks one stage ahead,
// so bubbles close up; when rsp_tready is low the finished result holds
// and earlier stages keep filling until the pipeline is full, and
// req_tready falls only then. Synchronous reset empties the pipeline; no
// result is presented in the cycle after reset.
module cubic_bezier_eval (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [16:0] param_t, [48:17] p0_coord, [80:49] p1_coord,
   // [112:81] p2_coord, [144:113] p3_coord, rest zero
   input  logic [cbe_pkg::REQ_W-1:0] req_tdata,
   // [1:0] req_type
   input  logic [cbe_pkg::SEL_W-1:0] req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [39:0] curve_value
   output logic [cbe_pkg::RSP_W-1:0] rsp_tdata
);
   import cbe_pkg::*;

   localparam int P0_LSB = T_W;
   localparam int P1_LSB = T_W + P_W;
   localparam int P2_LSB = T_W + 2 * P_W;
   localparam int P3_LSB = T_W + 3 * P_W;

   logic [STEPS:0] stg_valid;
   logic [STEPS:0] stg_ready;
   beat_type       stg_beat [STEPS+1];

   cbe_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .sel       (req_tuser),
      .param_t   (req_tdata[T_W-1:0]),
      .p0        (req_tdata[P0_LSB +: P_W]),
      .p1        (req_tdata[P1_LSB +: P_W]),
      .p2        (req_tdata[P2_LSB +: P_W]),
      .p3        (req_tdata[P3_LSB +: P_W]),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_beat  (stg_beat[0])
   );

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      cbe_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[i]),
         .in_ready  (stg_ready[i]),
         .in_beat   (stg_beat[i]),
         .out_valid (stg_valid[i+1]),
         .out_ready (stg_ready[i+1]),
         .out_beat  (stg_beat[i+1])
      );
   end

   assign stg_ready[STEPS] = rsp_tready;
   assign rsp_tvalid       = stg_valid[STEPS];
   assign rsp_tdata        = RSP_W'(stg_beat[STEPS].acc);

`ifndef SYNTHESIS
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled although the output side is ready");
   a_full_only: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result presented straight after reset");
`endif

endmodule
